// ----- rtl/kfll_pkg.sv -----
`default_nettype none
package kfll_pkg;

  // line modes
  localparam logic [3:0] MODE_START    = 4'd0;
  localparam logic [3:0] MODE_SECT     = 4'd1;
  localparam logic [3:0] MODE_SECT_BAD = 4'd2;
  localparam logic [3:0] MODE_COMMENT  = 4'd3;
  localparam logic [3:0] MODE_BLANK    = 4'd4;
  localparam logic [3:0] MODE_KEY      = 4'd5;
  localparam logic [3:0] MODE_LOCALE   = 4'd6;
  localparam logic [3:0] MODE_PRE_EQ   = 4'd7;
  localparam logic [3:0] MODE_VAL_LEAD = 4'd8;
  localparam logic [3:0] MODE_VALUE    = 4'd9;

  // token kinds
  localparam logic [2:0] TOK_SECT    = 3'd0;
  localparam logic [2:0] TOK_KEY     = 3'd1;
  localparam logic [2:0] TOK_LOCALE  = 3'd2;
  localparam logic [2:0] TOK_VALUE   = 3'd3;
  localparam logic [2:0] TOK_COMMENT = 3'd4;
  localparam logic [2:0] TOK_EOL     = 3'd5;
  localparam logic [2:0] TOK_ERROR   = 3'd6;
  localparam logic [2:0] TOK_EOT     = 3'd7;

  // line kinds
  localparam logic [1:0] LINE_COMMENT = 2'd0;
  localparam logic [1:0] LINE_SECT    = 2'd1;
  localparam logic [1:0] LINE_KEYVAL  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_SYNTAX = 2'd1;
  localparam logic [1:0] ERR_ESCAPE = 2'd2;
  localparam logic [1:0] ERR_KEY    = 2'd3;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [1:0] HDR_MIN = 2'h3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } kfll_in_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [7:0]  out_byte;
    logic [1:0]  line_kind;
    logic [1:0]  fault_code;
    logic [15:0] line_number;
    logic        last_of_run;
  } kfll_out_t;

  // up to two words produced by one accepted input word
  typedef struct packed {
    logic      valid0;
    logic      valid1;
    kfll_out_t word0;
    kfll_out_t word1;
  } kfll_push_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B) ||
           (b == 8'h0C) || (b == 8'h0D);
  endfunction

  function automatic logic is_key_char(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
           ((b >= 8'h30) && (b <= 8'h39)) || (b == 8'h2D);
  endfunction

  // msb set means the escape letter is not recognised
  function automatic logic [8:0] decode_escape(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      8'h73:   r = {1'b0, 8'h20};
      8'h74:   r = {1'b0, 8'h09};
      8'h6E:   r = {1'b0, 8'h0A};
      8'h72:   r = {1'b0, 8'h0D};
      8'h5C:   r = {1'b0, 8'h5C};
      default: r = {1'b1, 8'h00};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/key_file_line_lexer_unit.sv -----
// key file line lexer
// in channel: one text byte per word (in_data_i.text_byte), or an end of text
// marker (in_data_i.end_of_text, or a zero byte); taken when in_valid_i and
// in_ready_o are both high
// out channel: tagged words (section, key, locale, value, comment chars, line
// end with its kind, error with its code, text end), each with the current
// line number; last_of_run marks the final word caused by one input word
// latency: the words for a byte are visible on out_valid_o from the cycle after
// it is taken; the lexer state updates in that same edge
// throughput: one input word per cycle while in_ready_o is high; each byte
// gives at most one word, the end of text gives up to two (line end or error,
// then text end), drained by a four-word output queue at one word per cycle
// with out_ready_i high; stalls: in_ready_o stays high while the queue has at
// least two free slots, so input keeps flowing while a word waits on out_ready_i
// after an error, bytes are swallowed until the end of text
// reset: lexer back to line start with line number one, queue empty
`default_nettype none
module key_file_line_lexer_unit #(
  parameter int unsigned LINE_COUNT_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire kfll_pkg::kfll_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output kfll_pkg::kfll_out_t      out_data_o
);
  import kfll_pkg::*;

  logic       step;
  logic       pop;
  kfll_push_t push;

  // output queue
  kfll_out_t  q_mem [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] wr_d;
  logic [1:0] n_push;

  // accept only with room for the two-word end of text case
  assign in_ready_o = (cnt_q < 3'd3);
  assign step       = in_valid_i && in_ready_o;

  kfll_core #(
    .LINE_COUNT_BITS(LINE_COUNT_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .in_i  (in_data_i),
    .push_o(push)
  );

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = q_mem[rd_q];
  assign pop         = out_valid_o && out_ready_i;

  assign n_push = {1'b0, push.valid0} + {1'b0, push.valid1};
  assign wr_d   = wr_q + n_push;
  assign cnt_d  = cnt_q + {1'b0, n_push} - {2'b00, pop};

  // word1 only ever follows word0
  always_ff @(posedge clk_i) begin
    if (push.valid0) begin
      q_mem[wr_q] <= push.word0;
    end
    if (push.valid1) begin
      q_mem[wr_q + 2'd1] <= push.word1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
      if (pop) begin
        rd_q <= rd_q + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/kfll_core.sv -----
`default_nettype none
module kfll_core #(
  parameter int unsigned LINE_COUNT_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire kfll_pkg::kfll_in_t in_i,
  output kfll_pkg::kfll_push_t    push_o
);
  import kfll_pkg::*;

  localparam logic [LINE_COUNT_BITS-1:0] CountOne = {{(LINE_COUNT_BITS-1){1'b0}}, 1'b1};

  logic [3:0]                 mode_q, mode_d;
  logic [7:0]                 held_q, held_d;
  logic                       hv_q, hv_d;
  logic                       esc_q, esc_d;
  logic [1:0]                 hl_q, hl_d;
  logic [LINE_COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic                       halt_q, halt_d;

  logic [LINE_COUNT_BITS+15:0] ext_q, ext_inc;
  logic [15:0]                 ln_q, ln_inc;

  logic [7:0] b;
  logic       is_end;
  logic [8:0] dec_held, dec_in;

  // end-of-line evaluation
  logic       eol_fail;
  logic [1:0] eol_code;
  logic       eol_emit;
  logic [1:0] eol_lk;

  // first result fields
  logic       v0;
  logic [2:0] k0;
  logic [7:0] by0;
  logic [1:0] lk0, ec0;
  logic       te_second;
  logic [15:0] te_ln;

  assign b        = in_i.text_byte;
  assign is_end   = in_i.end_of_text || (b == CH_NUL);
  assign dec_held = decode_escape(held_q);
  assign dec_in   = decode_escape(b);

  assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + CountOne;
  assign ext_q   = {16'h0000, cnt_q};
  assign ext_inc = {16'h0000, cnt_inc};
  assign ln_q    = ext_q[15:0];
  assign ln_inc  = ext_inc[15:0];

  always_comb begin
    eol_fail = 1'b0;
    eol_code = ERR_NONE;
    eol_emit = 1'b0;
    eol_lk   = LINE_COMMENT;
    case (mode_q)
      MODE_SECT, MODE_SECT_BAD: begin
        if ((hl_q < HDR_MIN) || !hv_q || (held_q != CH_RBRK)) begin
          eol_fail = 1'b1;
          eol_code = ERR_SYNTAX;
        end else if ((mode_q == MODE_SECT_BAD) || esc_q) begin
          eol_fail = 1'b1;
          eol_code = ERR_ESCAPE;
        end else begin
          eol_emit = 1'b1;
          eol_lk   = LINE_SECT;
        end
      end
      MODE_KEY, MODE_LOCALE, MODE_PRE_EQ: begin
        eol_fail = 1'b1;
        eol_code = ERR_SYNTAX;
      end
      MODE_VALUE: begin
        if (esc_q) begin
          eol_fail = 1'b1;
          eol_code = ERR_ESCAPE;
        end else begin
          eol_emit = 1'b1;
          eol_lk   = LINE_KEYVAL;
        end
      end
      MODE_VAL_LEAD: begin
        eol_emit = 1'b1;
        eol_lk   = LINE_KEYVAL;
      end
      MODE_COMMENT, MODE_BLANK: begin
        eol_emit = 1'b1;
      end
      default: begin
        // line start: an empty line at the end of the text gives nothing
        eol_emit = !is_end;
      end
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    held_d    = held_q;
    hv_d      = hv_q;
    esc_d     = esc_q;
    hl_d      = hl_q;
    cnt_d     = cnt_q;
    halt_d    = halt_q;
    v0        = 1'b0;
    k0        = TOK_SECT;
    by0       = 8'h00;
    lk0       = LINE_COMMENT;
    ec0       = ERR_NONE;
    te_second = 1'b0;
    te_ln     = ln_q;

    if (is_end) begin
      if (!halt_q && eol_fail) begin
        v0        = 1'b1;
        k0        = TOK_ERROR;
        ec0       = eol_code;
        te_second = 1'b1;
      end else if (!halt_q && eol_emit) begin
        v0        = 1'b1;
        k0        = TOK_EOL;
        lk0       = eol_lk;
        te_second = 1'b1;
        te_ln     = ln_inc;
      end
      mode_d = MODE_START;
      held_d = 8'h00;
      hv_d   = 1'b0;
      esc_d  = 1'b0;
      hl_d   = 2'd0;
      cnt_d  = CountOne;
      halt_d = 1'b0;
    end else if (!halt_q) begin
      if (b == CH_LF) begin
        if (eol_fail) begin
          v0     = 1'b1;
          k0     = TOK_ERROR;
          ec0    = eol_code;
          halt_d = 1'b1;
        end else begin
          v0     = 1'b1;
          k0     = TOK_EOL;
          lk0    = eol_lk;
          cnt_d  = cnt_inc;
          mode_d = MODE_START;
          held_d = 8'h00;
          hv_d   = 1'b0;
          esc_d  = 1'b0;
          hl_d   = 2'd0;
        end
      end else begin
        case (mode_q)
          MODE_SECT, MODE_SECT_BAD: begin
            // the header byte is held one step so that ']' can end it
            if (hv_q && (mode_q == MODE_SECT)) begin
              if (esc_q) begin
                esc_d = 1'b0;
                if (dec_held[8]) begin
                  mode_d = MODE_SECT_BAD;
                end else begin
                  v0  = 1'b1;
                  k0  = TOK_SECT;
                  by0 = dec_held[7:0];
                end
              end else if (held_q == CH_BSLASH) begin
                esc_d = 1'b1;
              end else begin
                v0  = 1'b1;
                k0  = TOK_SECT;
                by0 = held_q;
              end
            end
            held_d = b;
            hv_d   = 1'b1;
            if (hl_q < HDR_MIN) begin
              hl_d = hl_q + 2'd1;
            end
          end
          MODE_COMMENT: begin
            v0  = 1'b1;
            k0  = TOK_COMMENT;
            by0 = b;
          end
          MODE_BLANK: begin
            v0 = 1'b1;
            if (is_space(b)) begin
              k0  = TOK_COMMENT;
              by0 = b;
            end else begin
              k0     = TOK_ERROR;
              ec0    = ERR_SYNTAX;
              halt_d = 1'b1;
            end
          end
          MODE_KEY: begin
            if (is_key_char(b)) begin
              v0  = 1'b1;
              k0  = TOK_KEY;
              by0 = b;
            end else if (b == CH_LBRK) begin
              mode_d = MODE_LOCALE;
            end else if (b == CH_SPACE) begin
              mode_d = MODE_PRE_EQ;
            end else if (b == CH_EQ) begin
              mode_d = MODE_VAL_LEAD;
            end else begin
              v0     = 1'b1;
              k0     = TOK_ERROR;
              ec0    = ERR_KEY;
              halt_d = 1'b1;
            end
          end
          MODE_LOCALE: begin
            if (b == CH_RBRK) begin
              mode_d = MODE_PRE_EQ;
            end else begin
              v0  = 1'b1;
              k0  = TOK_LOCALE;
              by0 = b;
            end
          end
          MODE_PRE_EQ: begin
            if (b == CH_EQ) begin
              mode_d = MODE_VAL_LEAD;
            end else if (b != CH_SPACE) begin
              v0     = 1'b1;
              k0     = TOK_ERROR;
              ec0    = ERR_KEY;
              halt_d = 1'b1;
            end
          end
          MODE_VAL_LEAD, MODE_VALUE: begin
            if (!((mode_q == MODE_VAL_LEAD) && (b == CH_SPACE))) begin
              mode_d = MODE_VALUE;
              if (esc_q) begin
                esc_d = 1'b0;
                v0    = 1'b1;
                if (dec_in[8]) begin
                  k0     = TOK_ERROR;
                  ec0    = ERR_ESCAPE;
                  halt_d = 1'b1;
                end else begin
                  k0  = TOK_VALUE;
                  by0 = dec_in[7:0];
                end
              end else if (b == CH_BSLASH) begin
                esc_d = 1'b1;
              end else begin
                v0  = 1'b1;
                k0  = TOK_VALUE;
                by0 = b;
              end
            end
          end
          default: begin
            if (b == CH_LBRK) begin
              mode_d = MODE_SECT;
              hl_d   = 2'd1;
              hv_d   = 1'b0;
              esc_d  = 1'b0;
            end else if (b == CH_HASH) begin
              mode_d = MODE_COMMENT;
              v0     = 1'b1;
              k0     = TOK_COMMENT;
              by0    = b;
            end else if (is_space(b)) begin
              mode_d = MODE_BLANK;
              v0     = 1'b1;
              k0     = TOK_COMMENT;
              by0    = b;
            end else if (is_key_char(b)) begin
              mode_d = MODE_KEY;
              v0     = 1'b1;
              k0     = TOK_KEY;
              by0    = b;
            end else begin
              v0     = 1'b1;
              k0     = TOK_ERROR;
              ec0    = ERR_SYNTAX;
              halt_d = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // text end goes first when no line result comes before it
  always_comb begin
    push_o = '0;
    if (step_i) begin
      if (is_end && !te_second) begin
        push_o.valid0 = 1'b1;
        push_o.word0  = '{token_kind: TOK_EOT, out_byte: 8'h00, line_kind: LINE_COMMENT,
                          fault_code: ERR_NONE, line_number: ln_q, last_of_run: 1'b1};
      end else begin
        push_o.valid0 = v0;
        push_o.valid1 = te_second;
        push_o.word0  = '{token_kind: k0, out_byte: by0, line_kind: lk0,
                          fault_code: ec0, line_number: ln_q, last_of_run: !te_second};
        push_o.word1  = '{token_kind: TOK_EOT, out_byte: 8'h00, line_kind: LINE_COMMENT,
                          fault_code: ERR_NONE, line_number: te_ln, last_of_run: 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      held_q <= 8'h00;
      hv_q   <= 1'b0;
      esc_q  <= 1'b0;
      hl_q   <= 2'd0;
      cnt_q  <= CountOne;
      halt_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      held_q <= held_d;
      hv_q   <= hv_d;
      esc_q  <= esc_d;
      hl_q   <= hl_d;
      cnt_q  <= cnt_d;
      halt_q <= halt_d;
    end
  end

endmodule
`default_nettype wire
